// ===== rtl/pidmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidmc_pkg
// Shared widths, register indices, reset values and payload types of the
// PI distance motor controller.
// ----------------------------------------------------------------------------
package pidmc_pkg;

  // Field widths
  localparam int DIST_BITS  = 10;
  localparam int DUTY_BITS  = 12;
  localparam int GAIN_BITS  = 16;   // Q8.8 gains and scale
  localparam int DB_BITS    = 10;
  localparam int INTEG_BITS = 32;   // Q24.8 integrator

  // Configuration port
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_SCALE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_MIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_MAX   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND   = 3'd5;

  // Reset values
  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 16'd2560;
  localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RST = 16'd34;
  localparam logic [GAIN_BITS-1:0] DUTY_SCALE_RST = 16'd1536;
  localparam logic [DUTY_BITS-1:0] DUTY_MIN_RST   = DUTY_BITS'(1200);
  localparam logic [DUTY_BITS-1:0] DUTY_MAX_RST   = DUTY_BITS'(3800);
  localparam logic [DB_BITS-1:0]   DEADBAND_RST   = 10'd1;

  // Datapath widths
  localparam int PACC_BITS = GAIN_BITS + DIST_BITS;
  localparam int CTRL_BITS = ((PACC_BITS > INTEG_BITS) ? PACC_BITS : INTEG_BITS) + 1;
  localparam int PROD_BITS = CTRL_BITS + GAIN_BITS;
  localparam int VAL_BITS  = CTRL_BITS + 1;
  localparam int MUL_STEPS = (DIST_BITS > GAIN_BITS) ? DIST_BITS : GAIN_BITS;
  localparam int CNT_BITS  = $clog2(MUL_STEPS);

  typedef struct packed {
    logic [DIST_BITS-1:0] measured_dist;
    logic [DIST_BITS-1:0] target_dist;
  } in_t;

  typedef struct packed {
    logic                 forward;
    logic                 run;
    logic [DUTY_BITS-1:0] duty;
  } out_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] prop_gain;
    logic [GAIN_BITS-1:0] integ_gain;
    logic [GAIN_BITS-1:0] duty_scale;
    logic [DUTY_BITS-1:0] duty_min;
    logic [DUTY_BITS-1:0] duty_max;
    logic [DB_BITS-1:0]   deadband;
  } cfg_t;

endpackage

// ===== rtl/pi_distance_motor_controller.sv =====
// ----------------------------------------------------------------------------
// pi_distance_motor_controller
// PI distance controller with clamped PWM duty output, bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one sample per
//   transaction: measured and target distance. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns one result per sample: direction, run
//   flag and clamped duty (duty reads zero when the motor is stopped).
//   Both gain products are formed one error bit per cycle, then the control
//   value is scaled one scale bit per cycle by a shift-add multiplier. A new
//   sample is taken only once the previous one has left the final step.
//   A finished result waits in the output register; the next sample is taken
//   meanwhile, and a result held back by out_stall_i stalls only the final
//   step of the following sample.
//   Reset restores the default gains and limits and clears the integrator.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   next clock edge and must be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module pi_distance_motor_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pidmc_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pidmc_pkg::out_t                      out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [pidmc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [pidmc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int DIST_BITS  = pidmc_pkg::DIST_BITS;
  localparam int DUTY_BITS  = pidmc_pkg::DUTY_BITS;
  localparam int GAIN_BITS  = pidmc_pkg::GAIN_BITS;
  localparam int INTEG_BITS = pidmc_pkg::INTEG_BITS;
  localparam int PACC_BITS  = pidmc_pkg::PACC_BITS;
  localparam int CTRL_BITS  = pidmc_pkg::CTRL_BITS;
  localparam int PROD_BITS  = pidmc_pkg::PROD_BITS;
  localparam int VAL_BITS   = pidmc_pkg::VAL_BITS;
  localparam int CNT_BITS   = pidmc_pkg::CNT_BITS;
  localparam int ISUM_BITS  = INTEG_BITS + 1;
  localparam int PSUM_BITS  = CTRL_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMUL,
    S_CTRL,
    S_SMUL,
    S_VAL,
    S_DONE
  } state_e;

  pidmc_pkg::cfg_t cfg;

  pidmc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  state_e                 state_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [DIST_BITS-1:0]   e_q;
  logic                   fwd_q;
  logic                   run_q;
  logic [PACC_BITS-1:0]   pacc_q;
  logic [PACC_BITS-1:0]   iacc_q;
  logic [CTRL_BITS-1:0]   ctrl_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [VAL_BITS-1:0]    val_q;
  logic [INTEG_BITS-1:0]  integ_q;
  pidmc_pkg::out_t        out_q;
  logic                   out_valid_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   in_fwd;
  logic [DIST_BITS-1:0]   in_err;
  logic [PACC_BITS-1:0]   pacc_d;
  logic [PACC_BITS-1:0]   iacc_d;
  logic [ISUM_BITS-1:0]   isum;
  logic [INTEG_BITS-1:0]  integ_d;
  logic [PSUM_BITS-1:0]   psum;
  logic [DUTY_BITS-1:0]   duty_clamped;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sign and magnitude of the error
  assign in_fwd = in_data_i.measured_dist > in_data_i.target_dist;
  assign in_err = in_fwd ? (in_data_i.measured_dist - in_data_i.target_dist)
                         : (in_data_i.target_dist - in_data_i.measured_dist);

  // One error bit per cycle, MSB first, into both gain products
  assign pacc_d = {pacc_q[PACC_BITS-2:0], 1'b0}
                + (e_q[DIST_BITS-1] ? PACC_BITS'(cfg.prop_gain) : '0);
  assign iacc_d = {iacc_q[PACC_BITS-2:0], 1'b0}
                + (e_q[DIST_BITS-1] ? PACC_BITS'(cfg.integ_gain) : '0);

  // Integrator update with saturation at full scale
  assign isum    = {1'b0, integ_q} + ISUM_BITS'(iacc_q);
  assign integ_d = isum[INTEG_BITS] ? '1 : isum[INTEG_BITS-1:0];

  // One scale bit per cycle, LSB first, shift-add into the high half
  assign psum = PSUM_BITS'(prod_q[PROD_BITS-1 -: CTRL_BITS]) + PSUM_BITS'(ctrl_q);

  // Upper clamp; the value never falls below duty_min
  assign duty_clamped = (val_q > VAL_BITS'(cfg.duty_max)) ? cfg.duty_max
                                                            : val_q[DUTY_BITS-1:0];

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      e_q         <= '0;
      fwd_q       <= 1'b0;
      run_q       <= 1'b0;
      pacc_q      <= '0;
      iacc_q      <= '0;
      ctrl_q      <= '0;
      prod_q      <= '0;
      val_q       <= '0;
      integ_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new result, or release the old one once the receiver takes it
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            fwd_q   <= in_fwd;
            run_q   <= in_err > cfg.deadband;
            e_q     <= in_err;
            pacc_q  <= '0;
            iacc_q  <= '0;
            cnt_q   <= CNT_BITS'(DIST_BITS - 1);
            state_q <= S_EMUL;
          end
        end
        S_EMUL: begin
          pacc_q <= pacc_d;
          iacc_q <= iacc_d;
          e_q    <= {e_q[DIST_BITS-2:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_CTRL;
          end
        end
        S_CTRL: begin
          // Control value uses the integrator before this sample's update
          ctrl_q  <= CTRL_BITS'(pacc_q) + CTRL_BITS'(integ_q);
          prod_q  <= {{CTRL_BITS{1'b0}}, cfg.duty_scale};
          integ_q <= run_q ? integ_d : '0;
          cnt_q   <= CNT_BITS'(GAIN_BITS - 1);
          state_q <= S_SMUL;
        end
        S_SMUL: begin
          if (prod_q[0]) begin
            prod_q <= {psum, prod_q[GAIN_BITS-1:1]};
          end else begin
            prod_q <= {1'b0, prod_q[PROD_BITS-1:1]};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_VAL;
          end
        end
        S_VAL: begin
          // Drop the Q33.16 fraction and add the duty offset
          val_q   <= VAL_BITS'(prod_q[PROD_BITS-1:GAIN_BITS]) + VAL_BITS'(cfg.duty_min);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.forward <= fwd_q;
            out_q.run     <= run_q;
            out_q.duty    <= run_q ? duty_clamped : '0;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A stopped motor reports zero duty
  a_stop_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run) |-> (out_data_o.duty == '0))
    else $error("duty not zero while motor stopped");

  // A running duty never exceeds the upper clamp
  a_duty_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.run) |-> (out_data_o.duty <= cfg.duty_max))
    else $error("duty above duty_max");

  // Inside the deadband the integrator clears
  a_integ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CTRL && !run_q) |=> (integ_q == '0))
    else $error("integrator not cleared in deadband");

  // A new result appears only from the final step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside final step");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("final step left while result stalled");

endmodule

// ===== rtl/pidmc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidmc_cfg_regs
// Configuration register file: indexed writes, masked to each register's
// width, reset to the default tuning.
// ----------------------------------------------------------------------------
module pidmc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pidmc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [pidmc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output pidmc_pkg::cfg_t                      cfg_o
);

  pidmc_pkg::cfg_t cfg_q;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= pidmc_pkg::PROP_GAIN_RST;
      cfg_q.integ_gain <= pidmc_pkg::INTEG_GAIN_RST;
      cfg_q.duty_scale <= pidmc_pkg::DUTY_SCALE_RST;
      cfg_q.duty_min   <= pidmc_pkg::DUTY_MIN_RST;
      cfg_q.duty_max   <= pidmc_pkg::DUTY_MAX_RST;
      cfg_q.deadband   <= pidmc_pkg::DEADBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidmc_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data_i[pidmc_pkg::GAIN_BITS-1:0];
        pidmc_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data_i[pidmc_pkg::GAIN_BITS-1:0];
        pidmc_pkg::REG_DUTY_SCALE: cfg_q.duty_scale <= cfg_data_i[pidmc_pkg::GAIN_BITS-1:0];
        pidmc_pkg::REG_DUTY_MIN:   cfg_q.duty_min   <= cfg_data_i[pidmc_pkg::DUTY_BITS-1:0];
        pidmc_pkg::REG_DUTY_MAX:   cfg_q.duty_max   <= cfg_data_i[pidmc_pkg::DUTY_BITS-1:0];
        pidmc_pkg::REG_DEADBAND:   cfg_q.deadband   <= cfg_data_i[pidmc_pkg::DB_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PI distance motor controller. A queue-fed driver
// sends distance samples and a monitor checks every returned drive command
// against an in-bench PI predictor that tracks the integrator and the
// register file. Phases cover reset values, extreme, inverted-clamp, zeroed
// and random register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIST_BITS     = pidmc_pkg::DIST_BITS;
  localparam int DUTY_BITS     = pidmc_pkg::DUTY_BITS;
  localparam int DB_BITS       = pidmc_pkg::DB_BITS;
  localparam int INTEG_BITS    = pidmc_pkg::INTEG_BITS;
  localparam int CFG_IDX_BITS  = pidmc_pkg::CFG_IDX_BITS;
  localparam int CFG_DATA_BITS = pidmc_pkg::CFG_DATA_BITS;

  localparam int RESULT_LATENCY = 29;
  localparam int CYCLE_LIMIT    = 750000;
  localparam int PRINT_LIMIT    = 40;

  // Indices past the register list, which the block must ignore
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    SET_HIGH,
    SET_LOW,
    SET_INVERTED,
    SET_DEFAULT,
    SET_RANDOM
  } setting_e;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     in_valid_i = 1'b0;
  pidmc_pkg::in_t           in_data_i  = '0;
  logic                     out_stall_i = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  pidmc_pkg::out_t          out_data_o;

  // Register mirror and integrator of the predictor
  pidmc_pkg::cfg_t       shadow = '{prop_gain:  pidmc_pkg::PROP_GAIN_RST,
                                    integ_gain: pidmc_pkg::INTEG_GAIN_RST,
                                    duty_scale: pidmc_pkg::DUTY_SCALE_RST,
                                    duty_min:   pidmc_pkg::DUTY_MIN_RST,
                                    duty_max:   pidmc_pkg::DUTY_MAX_RST,
                                    deadband:   pidmc_pkg::DEADBAND_RST};
  logic [INTEG_BITS-1:0] integ_acc = '0;

  pidmc_pkg::in_t  pending_q[$];
  pidmc_pkg::out_t drive_q[$];

  int   n_queued    = 0;
  int   n_samples   = 0;
  int   n_results   = 0;
  int   n_running   = 0;
  int   n_saturated = 0;
  int   n_settings  = 0;
  int   fail_cnt    = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  int   quiet_left  = 0;
  logic quiet_q     = 1'b0;
  logic draining    = 1'b0;

  pi_distance_motor_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  // Advance the PI law by one sample and return the drive command
  function automatic pidmc_pkg::out_t next_drive(pidmc_pkg::in_t smp);
    logic                 fwd;
    logic [DIST_BITS-1:0] err;
    logic [63:0]          ctrl;
    logic [63:0]          scaled;
    logic [63:0]          nxt;
    pidmc_pkg::out_t      res;
    fwd    = smp.measured_dist > smp.target_dist;
    err    = fwd ? smp.measured_dist - smp.target_dist
                 : smp.target_dist - smp.measured_dist;
    ctrl   = 64'(shadow.prop_gain) * 64'(err) + 64'(integ_acc);
    // Offset is added after scaling, so the value never falls below duty_min
    scaled = ((ctrl * 64'(shadow.duty_scale)) >> 16) + 64'(shadow.duty_min);
    res.forward = fwd;
    if (err > shadow.deadband) begin
      nxt = 64'(integ_acc) + 64'(shadow.integ_gain) * 64'(err);
      if (nxt > 64'({INTEG_BITS{1'b1}})) begin
        integ_acc = '1;
        n_saturated++;
      end else begin
        integ_acc = nxt[INTEG_BITS-1:0];
      end
      res.run  = 1'b1;
      res.duty = (scaled > 64'(shadow.duty_max)) ? shadow.duty_max
                                                 : scaled[DUTY_BITS-1:0];
      n_running++;
    end else begin
      integ_acc = '0;
      res.run   = 1'b0;
      res.duty  = '0;
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(99);
    if (quiet_q) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Random sample: wide errors, errors around the deadband, equal and uniform
  function automatic pidmc_pkg::in_t random_sample(bit windup);
    int              cat;
    int              e;
    int              lo;
    pidmc_pkg::in_t  smp;
    cat = $urandom_range(99);
    if (windup || cat < 20) begin
      smp.measured_dist = DIST_BITS'($urandom_range(0, 63));
      smp.target_dist   = DIST_BITS'($urandom_range(960, 1023));
    end else if (cat < 45) begin
      e = int'(shadow.deadband) + $urandom_range(0, 2) - 1;
      if (e < 0) e = 0;
      if (e > 1023) e = 1023;
      lo = $urandom_range(1023 - e);
      smp.measured_dist = DIST_BITS'(lo);
      smp.target_dist   = DIST_BITS'(lo + e);
    end else if (cat < 55) begin
      smp.measured_dist = DIST_BITS'($urandom_range(1023));
      smp.target_dist   = smp.measured_dist;
    end else begin
      smp.measured_dist = DIST_BITS'($urandom_range(1023));
      smp.target_dist   = DIST_BITS'($urandom_range(1023));
    end
    if (!(cat < 55 && cat >= 45) && $urandom_range(1)) begin
      smp = '{measured_dist: smp.target_dist, target_dist: smp.measured_dist};
    end
    return smp;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_cnt < PRINT_LIMIT) begin
      $display("[%0t] result %0d: %s got %0d expected %0d",
               $time, n_results, what, got, want);
    end
    fail_cnt++;
  endtask

  task automatic queue_sample(int meas, int targ);
    pending_q.push_back('{measured_dist: DIST_BITS'(meas), target_dist: DIST_BITS'(targ)});
    n_queued++;
  endtask

  // Hold until every queued sample has returned its command
  task automatic wait_idle();
    while (n_results < n_queued) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      pidmc_pkg::REG_PROP_GAIN:  shadow.prop_gain  = data;
      pidmc_pkg::REG_INTEG_GAIN: shadow.integ_gain = data;
      pidmc_pkg::REG_DUTY_SCALE: shadow.duty_scale = data;
      pidmc_pkg::REG_DUTY_MIN:   shadow.duty_min   = data[DUTY_BITS-1:0];
      pidmc_pkg::REG_DUTY_MAX:   shadow.duty_max   = data[DUTY_BITS-1:0];
      pidmc_pkg::REG_DEADBAND:   shadow.deadband   = data[DB_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_e which);
    case (which)
      SET_HIGH: begin
        write_reg(pidmc_pkg::REG_PROP_GAIN,  16'hFFFF);
        write_reg(pidmc_pkg::REG_INTEG_GAIN, 16'hFFFF);
        write_reg(pidmc_pkg::REG_DUTY_SCALE, 16'hFFFF);
        write_reg(pidmc_pkg::REG_DUTY_MIN,   16'h0000);
        write_reg(pidmc_pkg::REG_DUTY_MAX,   16'hFFFF);
        write_reg(pidmc_pkg::REG_DEADBAND,   16'h0000);
      end
      SET_LOW: begin
        // Upper data bits set: limits and deadband keep only their low bits
        write_reg(pidmc_pkg::REG_PROP_GAIN,  16'h0000);
        write_reg(pidmc_pkg::REG_INTEG_GAIN, 16'h0000);
        write_reg(pidmc_pkg::REG_DUTY_SCALE, 16'h0000);
        write_reg(pidmc_pkg::REG_DUTY_MIN,   16'hFFFF);
        write_reg(pidmc_pkg::REG_DUTY_MAX,   16'hF000);
        write_reg(pidmc_pkg::REG_DEADBAND,   16'hFFFF);
      end
      SET_INVERTED: begin
        write_reg(pidmc_pkg::REG_PROP_GAIN,  16'(pidmc_pkg::PROP_GAIN_RST));
        write_reg(pidmc_pkg::REG_INTEG_GAIN, 16'(pidmc_pkg::INTEG_GAIN_RST));
        write_reg(pidmc_pkg::REG_DUTY_SCALE, 16'(pidmc_pkg::DUTY_SCALE_RST));
        write_reg(pidmc_pkg::REG_DUTY_MIN,   16'd3000);
        write_reg(pidmc_pkg::REG_DUTY_MAX,   16'd500);
        write_reg(pidmc_pkg::REG_DEADBAND,   16'd3);
      end
      SET_DEFAULT: begin
        // Writes past the register list must leave everything untouched
        write_reg(REG_SPARE_LO,              CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_HI,              CFG_DATA_BITS'($urandom));
        write_reg(pidmc_pkg::REG_PROP_GAIN,  16'(pidmc_pkg::PROP_GAIN_RST));
        write_reg(pidmc_pkg::REG_INTEG_GAIN, 16'(pidmc_pkg::INTEG_GAIN_RST));
        write_reg(pidmc_pkg::REG_DUTY_SCALE, 16'(pidmc_pkg::DUTY_SCALE_RST));
        write_reg(pidmc_pkg::REG_DUTY_MIN,   16'(pidmc_pkg::DUTY_MIN_RST));
        write_reg(pidmc_pkg::REG_DUTY_MAX,   16'(pidmc_pkg::DUTY_MAX_RST));
        write_reg(pidmc_pkg::REG_DEADBAND,   16'(pidmc_pkg::DEADBAND_RST));
        write_reg(REG_SPARE_HI,              CFG_DATA_BITS'($urandom));
      end
      default: begin
        write_reg(pidmc_pkg::REG_PROP_GAIN,  CFG_DATA_BITS'($urandom));
        write_reg(pidmc_pkg::REG_INTEG_GAIN, CFG_DATA_BITS'($urandom_range(0, 600)));
        write_reg(pidmc_pkg::REG_DUTY_SCALE, CFG_DATA_BITS'($urandom));
        write_reg(pidmc_pkg::REG_DUTY_MIN,   CFG_DATA_BITS'($urandom));
        write_reg(pidmc_pkg::REG_DUTY_MAX,   CFG_DATA_BITS'($urandom));
        write_reg(pidmc_pkg::REG_DEADBAND,
                  $urandom_range(3) == 0 ? CFG_DATA_BITS'($urandom)
                                         : CFG_DATA_BITS'($urandom_range(15)));
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(int count, bit windup);
    repeat (count) begin
      pending_q.push_back(random_sample(windup));
      n_queued++;
    end
    wait_idle();
  endtask

  // Alternate calm stretches with ones where both sides idle at random
  always @(posedge clk_i) begin : pacing
    if (quiet_left == 0) begin
      quiet_q    <= ($urandom_range(3) == 0);
      quiet_left  = $urandom_range(50, 300);
    end else begin
      quiet_left--;
    end
  end

  // Drive samples from the pending queue; predict each accepted transaction
  always @(posedge clk_i) begin : sample_driver
    logic           nxt_valid;
    pidmc_pkg::in_t nxt_data;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        drive_q.push_back(next_drive(in_data_i));
        n_samples++;
        nxt_valid = 1'b0;
        gap_left  = idle_span();
        if (!quiet_q && $urandom_range(199) == 0) draining = 1'b1;
      end
      if (!nxt_valid) begin
        if (draining && drive_q.size() == 0) draining = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!draining && pending_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = pending_q.pop_front();
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
    end
  end

  // Check each result transaction against the oldest predicted command
  always @(posedge clk_i) begin : result_monitor
    pidmc_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch("result with no sample outstanding, duty", out_data_o.duty, 0);
        end else begin
          want = drive_q.pop_front();
          if (out_data_o.forward !== want.forward)
            report_mismatch("forward", out_data_o.forward, want.forward);
          if (out_data_o.run !== want.run)
            report_mismatch("run", out_data_o.run, want.run);
          if (out_data_o.duty !== want.duty)
            report_mismatch("duty", out_data_o.duty, want.duty);
        end
        n_results++;
      end
      if (stall_left == 0 && !quiet_q && $urandom_range(3) == 0) stall_left = idle_span();
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d of %0d results", CYCLE_LIMIT, n_results, n_queued);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero error, deadband edges, full-scale errors, integrator growth
    queue_sample(500, 500);
    queue_sample(501, 500);
    queue_sample(500, 501);
    queue_sample(502, 500);
    queue_sample(500, 502);
    queue_sample(1023, 0);
    queue_sample(0, 1023);
    queue_sample(0, 0);
    queue_sample(1023, 1023);
    queue_sample(1023, 1020);
    queue_sample(1023, 1020);
    queue_sample(1023, 1020);
    queue_sample(10, 13);
    queue_sample(13, 10);
    queue_sample(10'h2AA, 10'h155);
    queue_sample(10'h155, 10'h2AA);
    queue_sample(700, 700);
    wait_idle();

    // Random phases over reset values, extremes, zeroed settings, inverted clamp and random sets
    run_phase(200, 1'b0);
    apply_setting(SET_HIGH);
    run_phase(120, 1'b1);
    apply_setting(SET_LOW);
    run_phase(40, 1'b0);
    apply_setting(SET_INVERTED);
    run_phase(120, 1'b0);
    apply_setting(SET_DEFAULT);
    run_phase(150, 1'b0);
    repeat (4) begin
      apply_setting(SET_RANDOM);
      run_phase(100, 1'b0);
    end

    repeat (2 * RESULT_LATENCY) @(posedge clk_i);
    if (drive_q.size() != 0) report_mismatch("commands never returned", 0, drive_q.size());
    $display("%0d samples over %0d register settings; %0d drove the motor, %0d hit the",
             n_samples, n_settings, n_running, n_saturated);
    $display("integrator ceiling; %0d mismatches", fail_cnt);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
